@@ src/srad_pkg.sv @@
`default_nettype none
package srad_pkg;
    localparam int unsigned DC_GAIN = 1865841;
    localparam int unsigned ROT_GAIN = 1484360;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;
    localparam int unsigned SQRT_STAGES = 4;
    localparam int unsigned SQRT_STEPS = 4;
    localparam int unsigned SCALE_STAGES = 3;
    localparam int unsigned PIPE_DEPTH = 2 + SQRT_STAGES;

    typedef struct packed {
        logic [7:0]  color_red;
        logic [7:0]  color_green;
        logic [7:0]  color_blue;
        logic [7:0]  opacity_code;
        logic [15:0] scale_code_x;
        logic [15:0] scale_code_y;
        logic [15:0] scale_code_z;
        logic [31:0] rotation_word;
        logic        last_in;
    } rec_in_t;

    typedef struct packed {
        logic signed [15:0] dc_red;
        logic signed [15:0] dc_green;
        logic signed [15:0] dc_blue;
        logic [15:0]        alpha_out;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic               last_out;
    } rec_out_t;

    // Sign-magnitude multiply by a Q16 gain with rounding; |n| <= 1023.
    function automatic logic signed [15:0] gain_round(input logic signed [11:0] n,
                                                      input logic [20:0] k);
        logic [10:0] mag;
        logic [31:0] prod;
        logic [15:0] r;
        mag = n[11] ? 11'(-n) : n[10:0];
        prod = 32'(mag) * 32'(k) + 32'd32768;
        r = prod[31:16];
        return n[11] ? -$signed(r) : $signed(r);
    endfunction

    // Opacity table b*32768+127 div 255 done by reciprocal: exact for b <= 255.
    function automatic logic [15:0] alpha_of(input logic [7:0] b);
        logic [23:0] num;
        logic [47:0] p;
        logic [15:0] q;
        num = {1'b0, b, 15'd0} + 24'd127;
        p = 48'(num) * 48'd16843010;
        q = p[47:32];
        if (24'(q) * 24'd255 + 24'd255 <= num) q = q + 16'd1;
        return q;
    endfunction

    localparam logic [1:0] PERM [16] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2,
                                         2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3};
endpackage
`default_nettype wire

@@ src/srad_scale.sv @@
`default_nettype none
module srad_scale (
    input  wire                aclk,
    input  wire                en,
    input  wire signed [31:0]  lo,
    input  wire signed [31:0]  hi,
    input  wire        [15:0]  code,
    output logic signed [31:0] result
);
    // Stage 1: range and product. Stage 2: divide magnitude by 65535 with reciprocal.
    // Stage 3: correction and final add.
    logic signed [32:0] lo1_reg, lo2_reg;
    logic signed [49:0] t_reg;
    logic        [48:0] mag;
    logic               neg_reg;
    logic        [33:0] q_reg;
    logic        [49:0] rem_reg;
    logic signed [32:0] diff;
    logic        [49:0] madd;
    logic        [33:0] qe;
    logic        [49:0] r;
    logic        [33:0] qf;
    logic signed [34:0] s;

    assign diff = 33'(hi) - 33'(lo);
    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg   <= 50'(diff) * $signed({34'd0, code});
            lo1_reg <= 33'(lo);
        end
    end

    always_comb begin
        mag = t_reg[49] ? 49'(-t_reg) : t_reg[48:0];
        madd = 50'(mag) + 50'd32767;
        // madd/65535 ~= (madd + (madd>>16) ) >> 16, error below one
        qe = 34'((madd + (madd >> 16)) >> 16);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg   <= qe;
            rem_reg <= madd;
            neg_reg <= t_reg[49];
            lo2_reg <= lo1_reg;
        end
    end

    always_comb begin
        r  = rem_reg - 50'(q_reg) * 50'd65535;
        qf = q_reg;
        if (r[49]) qf = q_reg - 34'd1;
        else if (r >= 50'd65535) qf = q_reg + 34'd1;
        s = neg_reg ? 35'(lo2_reg) - $signed({1'b0, qf}) : 35'(lo2_reg) + $signed({1'b0, qf});
    end

    always_ff @(posedge aclk) begin
        if (en) result <= s[31:0];
    end
endmodule
`default_nettype wire

@@ src/srad_quat.sv @@
`default_nettype none
module srad_quat (
    input  wire                aclk,
    input  wire                en,
    input  wire  [31:0]        rot,
    output logic signed [15:0] qx,
    output logic signed [15:0] qy,
    output logic signed [15:0] qz,
    output logic signed [15:0] qw
);
    import srad_pkg::*;
    logic signed [15:0] v1_reg [3];
    logic [1:0]         s1_reg;
    logic signed [15:0] v_reg [SQRT_STAGES][3];
    logic [1:0]         slot_reg [SQRT_STAGES];
    logic               zero_reg [SQRT_STAGES];
    logic [31:0]        x_reg [SQRT_STAGES];
    logic [31:0]        res_reg [SQRT_STAGES];
    logic signed [15:0] vc [3];
    logic [31:0]        dot;
    logic [31:0]        x_c [SQRT_STAGES];
    logic [31:0]        res_c [SQRT_STAGES];
    logic [31:0]        x, res, b;
    logic [31:0]        res_rnd;
    logic [15:0]        w;
    logic signed [15:0] v4 [4];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vc[k] = gain_round(12'($signed({2'b00, rot[10*k +: 10]}) * 2) - 12'sd1023,
                               21'(ROT_GAIN));
        end
    end

    always_comb begin
        dot = 32'(v1_reg[0] * v1_reg[0]) + 32'(v1_reg[1] * v1_reg[1])
            + 32'(v1_reg[2] * v1_reg[2]);
    end

    // Bit-pair square root over radicand of at most 2^30, a few bit pairs per stage.
    always_comb begin
        for (int j = 0; j < SQRT_STAGES; j++) begin
            x = x_reg[j];
            res = res_reg[j];
            for (int i = 0; i < SQRT_STEPS; i++) begin
                b = 32'd1 << (2 * (SQRT_STAGES * SQRT_STEPS - 1 - SQRT_STEPS * j - i));
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
            end
            x_c[j] = x;
            res_c[j] = res;
        end
    end

    always_comb begin
        res_rnd = res_c[SQRT_STAGES-1];
        if (x_c[SQRT_STAGES-1] > res_rnd) res_rnd = res_rnd + 32'd1;
        w = zero_reg[SQRT_STAGES-1] ? 16'd0
          : (res_rnd > 32'd32767 ? 16'd32767 : res_rnd[15:0]);
        v4[0] = v_reg[SQRT_STAGES-1][0];
        v4[1] = v_reg[SQRT_STAGES-1][1];
        v4[2] = v_reg[SQRT_STAGES-1][2];
        v4[3] = $signed(w);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg      <= vc;
            s1_reg      <= rot[31:30];
            v_reg[0]    <= v1_reg;
            slot_reg[0] <= s1_reg;
            zero_reg[0] <= dot >= 32'h4000_0000;
            x_reg[0]    <= 32'h4000_0000 - dot;
            res_reg[0]  <= '0;
            for (int j = 1; j < SQRT_STAGES; j++) begin
                v_reg[j]    <= v_reg[j-1];
                slot_reg[j] <= slot_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                x_reg[j]    <= x_c[j-1];
                res_reg[j]  <= res_c[j-1];
            end
            qx <= v4[PERM[{slot_reg[SQRT_STAGES-1], 2'd0}]];
            qy <= v4[PERM[{slot_reg[SQRT_STAGES-1], 2'd1}]];
            qz <= v4[PERM[{slot_reg[SQRT_STAGES-1], 2'd2}]];
            qw <= v4[PERM[{slot_reg[SQRT_STAGES-1], 2'd3}]];
        end
    end
endmodule
`default_nettype wire

@@ src/splat_record_attribute_decoder.sv @@
// Channel  | Ports                                  | Handshake
// request  | s_valid, s_ready, s_* fields           | valid/ready
// result   | m_valid, m_ready, m_* fields           | valid/ready
// config   | cfg_we, cfg_index, cfg_data            | write enable
// Six pipeline stages; one record per cycle unless the whole pipeline stalls on m_ready, and
// an accepted request is offered as a result once it has passed all six. The square root
// takes four stages. The pipeline advances whenever its last stage is empty or being taken.
// Synchronous active-low reset clears valid bits and config registers.
`default_nettype none
module splat_record_attribute_decoder (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_color_red,
    input  wire  [7:0]  s_color_green,
    input  wire  [7:0]  s_color_blue,
    input  wire  [7:0]  s_opacity_code,
    input  wire  [15:0] s_scale_code_x,
    input  wire  [15:0] s_scale_code_y,
    input  wire  [15:0] s_scale_code_z,
    input  wire  [31:0] s_rotation_word,
    input  wire         s_last_in,
    output logic        m_valid,
    input  wire         m_ready,
    output logic signed [15:0] m_dc_red,
    output logic signed [15:0] m_dc_green,
    output logic signed [15:0] m_dc_blue,
    output logic [15:0] m_alpha_out,
    output logic signed [31:0] m_scale_x,
    output logic signed [31:0] m_scale_y,
    output logic signed [31:0] m_scale_z,
    output logic signed [15:0] m_quat_x,
    output logic signed [15:0] m_quat_y,
    output logic signed [15:0] m_quat_z,
    output logic signed [15:0] m_quat_w,
    output logic        m_last_out
);
    import srad_pkg::*;
    logic [31:0] cfg_reg [6];
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic       adv;
    logic signed [15:0] dc_reg [PIPE_DEPTH-1][3];
    logic [15:0] al_reg [PIPE_DEPTH-1];
    logic [PIPE_DEPTH-2:0] last_reg;
    logic [15:0] code_reg [PIPE_DEPTH-SCALE_STAGES][3];
    logic signed [15:0] dcc [3];
    logic [7:0] col [3];

    assign adv = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            for (int i = 0; i < 6; i++) cfg_reg[i] <= '0;
        end else begin
            if (adv) vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MIN_X: cfg_reg[0] <= cfg_data;
                    REG_MIN_Y: cfg_reg[1] <= cfg_data;
                    REG_MIN_Z: cfg_reg[2] <= cfg_data;
                    REG_MAX_X: cfg_reg[3] <= cfg_data;
                    REG_MAX_Y: cfg_reg[4] <= cfg_data;
                    REG_MAX_Z: cfg_reg[5] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign col[0] = s_color_red;
    assign col[1] = s_color_green;
    assign col[2] = s_color_blue;
    always_comb begin
        for (int k = 0; k < 3; k++)
            dcc[k] = gain_round($signed({3'b000, col[k], 1'b0}) - 12'sd255, 21'(DC_GAIN));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dc_reg[0]   <= dcc;
            al_reg[0]   <= alpha_of(s_opacity_code);
            last_reg    <= {last_reg[PIPE_DEPTH-3:0], s_last_in};
            code_reg[0] <= '{s_scale_code_x, s_scale_code_y, s_scale_code_z};
            for (int j = 1; j < PIPE_DEPTH - 1; j++) begin
                dc_reg[j] <= dc_reg[j-1];
                al_reg[j] <= al_reg[j-1];
            end
            for (int j = 1; j < PIPE_DEPTH - SCALE_STAGES; j++) code_reg[j] <= code_reg[j-1];
            m_dc_red    <= dc_reg[PIPE_DEPTH-2][0];
            m_dc_green  <= dc_reg[PIPE_DEPTH-2][1];
            m_dc_blue   <= dc_reg[PIPE_DEPTH-2][2];
            m_alpha_out <= al_reg[PIPE_DEPTH-2];
            m_last_out  <= last_reg[PIPE_DEPTH-2];
        end
    end

    srad_scale u_sx (.aclk(aclk), .en(adv), .lo(cfg_reg[0]), .hi(cfg_reg[3]),
                     .code(code_reg[PIPE_DEPTH-SCALE_STAGES-1][0]), .result(m_scale_x));
    srad_scale u_sy (.aclk(aclk), .en(adv), .lo(cfg_reg[1]), .hi(cfg_reg[4]),
                     .code(code_reg[PIPE_DEPTH-SCALE_STAGES-1][1]), .result(m_scale_y));
    srad_scale u_sz (.aclk(aclk), .en(adv), .lo(cfg_reg[2]), .hi(cfg_reg[5]),
                     .code(code_reg[PIPE_DEPTH-SCALE_STAGES-1][2]), .result(m_scale_z));
    srad_quat u_q (.aclk(aclk), .en(adv), .rot(s_rotation_word),
                   .qx(m_quat_x), .qy(m_quat_y), .qz(m_quat_z), .qw(m_quat_w));

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("stall without result");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0]) else $error("request lost");
`endif
endmodule
`default_nettype wire
